FILE: hdl/apr_pkg.sv
package apr_pkg;

  localparam int SUM_FRACTION_BITS_DEF = 16;
  localparam int GAMMA_INDEX_BITS_DEF  = 12;

  localparam int SUM_W    = 32;
  localparam int COUNT_W  = 24;
  localparam int BYTE_W   = 8;
  localparam int CHANNELS = 3;
  localparam int LEVELS   = 256;
  localparam int THR_W    = 17;
  localparam int BIG_W    = 256;

  localparam int GAMMA_SCALE = 25599;
  localparam int LEVEL_SCALE = 100;
  localparam int GAMMA_NUM   = 5;
  localparam int GAMMA_DEN   = 11;

  typedef struct packed {
    logic                valid;
    logic                blank;
    logic [CHANNELS-1:0] sat;
  } apr_ctl_t;

  // smallest index x with x^5 * 25599^11 >= (100*level)^11 * 2^(5*idx_bits)
  function automatic logic [THR_W-1:0] gamma_threshold(input int level, input int idx_bits);
    logic [BIG_W-1:0] lhs;
    logic [BIG_W-1:0] rhs;
    logic [BIG_W-1:0] radix;
    logic [BIG_W-1:0] lo;
    logic [BIG_W-1:0] hi;
    logic [BIG_W-1:0] mid;
    lhs = BIG_W'(1);
    for (int k = 0; k < GAMMA_DEN; k++) begin
      lhs = lhs * BIG_W'(LEVEL_SCALE * level);
    end
    lhs = lhs << (GAMMA_NUM * idx_bits);
    radix = BIG_W'(1);
    for (int k = 0; k < GAMMA_DEN; k++) begin
      radix = radix * BIG_W'(GAMMA_SCALE);
    end
    lo = '0;
    hi = BIG_W'(1) << idx_bits;
    for (int it = 0; it <= THR_W; it++) begin
      if (lo < hi) begin
        mid = (lo + hi) >> 1;
        rhs = radix;
        for (int k = 0; k < GAMMA_NUM; k++) begin
          rhs = rhs * mid;
        end
        if (rhs >= lhs) begin
          hi = mid;
        end else begin
          lo = mid + BIG_W'(1);
        end
      end
    end
    return lo[THR_W-1:0];
  endfunction

endpackage

FILE: hdl/apr_div_stage.sv
module apr_div_stage #(
  parameter int DW = 40,
  parameter int G  = 12
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  apr_pkg::apr_ctl_t                     ctl_in,
  input  logic [DW-1:0]                         div_in,
  input  logic [apr_pkg::CHANNELS-1:0][DW-1:0]  rem_in,
  input  logic [apr_pkg::CHANNELS-1:0][G-1:0]   quo_in,
  output apr_pkg::apr_ctl_t                     ctl_out,
  output logic [DW-1:0]                         div_out,
  output logic [apr_pkg::CHANNELS-1:0][DW-1:0]  rem_out,
  output logic [apr_pkg::CHANNELS-1:0][G-1:0]   quo_out
);

  logic [apr_pkg::CHANNELS-1:0][DW-1:0] rem_next;
  logic [apr_pkg::CHANNELS-1:0][G-1:0]  quo_next;

  always_comb begin
    logic [DW:0] dbl;
    logic [DW:0] diff;
    for (int c = 0; c < apr_pkg::CHANNELS; c++) begin
      dbl  = {rem_in[c], 1'b0};
      diff = dbl - {1'b0, div_in};
      if (dbl >= {1'b0, div_in}) begin
        rem_next[c] = diff[DW-1:0];
        quo_next[c] = {quo_in[c][G-2:0], 1'b1};
      end else begin
        rem_next[c] = dbl[DW-1:0];
        quo_next[c] = {quo_in[c][G-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.blank <= ctl_in.blank;
    ctl_out.sat   <= ctl_in.sat;
    div_out       <= div_in;
    rem_out       <= rem_next;
    quo_out       <= quo_next;
  end

endmodule

FILE: hdl/apr_gamma_stage.sv
module apr_gamma_stage #(
  parameter int G   = 12,
  parameter int BIT = 7
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  apr_pkg::apr_ctl_t                                 ctl_in,
  input  logic [apr_pkg::CHANNELS-1:0][G-1:0]               idx_in,
  input  logic [apr_pkg::CHANNELS-1:0][apr_pkg::BYTE_W-1:0] code_in,
  output apr_pkg::apr_ctl_t                                 ctl_out,
  output logic [apr_pkg::CHANNELS-1:0][G-1:0]               idx_out,
  output logic [apr_pkg::CHANNELS-1:0][apr_pkg::BYTE_W-1:0] code_out
);

  localparam int TW = G + 1;
  localparam logic [apr_pkg::BYTE_W-1:0] MASK = apr_pkg::BYTE_W'(1 << BIT);

  typedef logic [TW-1:0] thr_t [apr_pkg::LEVELS];

  function automatic thr_t build_thr();
    thr_t t;
    for (int b = 0; b < apr_pkg::LEVELS; b++) begin
      t[b] = TW'(apr_pkg::gamma_threshold(b, G));
    end
    return t;
  endfunction

  localparam thr_t THR = build_thr();

  logic [apr_pkg::CHANNELS-1:0][apr_pkg::BYTE_W-1:0] code_next;

  always_comb begin
    logic [apr_pkg::BYTE_W-1:0] cand;
    for (int c = 0; c < apr_pkg::CHANNELS; c++) begin
      cand = code_in[c] | MASK;
      if (THR[cand] <= {1'b0, idx_in[c]}) begin
        code_next[c] = cand;
      end else begin
        code_next[c] = code_in[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.blank <= ctl_in.blank;
    ctl_out.sat   <= ctl_in.sat;
    idx_out       <= idx_in;
    code_out      <= code_next;
  end

endmodule

FILE: hdl/accumulated_pixel_resolve_gamma.sv
// Resolves one accumulated pixel per clock into gamma-corrected 8-bit RGB. A transaction is
// taken on every cycle that start is high; busy is always low. Each result appears on
// red_byte, green_byte and blue_byte for one cycle with done high, after passing through one
// input register, one restoring-division stage per bit of the gamma index, eight
// binary-search stages over the 256 gamma thresholds, and one output register. Results
// come out in order and cannot be held off. A zero sample count gives black; a mean of
// 1.0 or more gives 255.
module accumulated_pixel_resolve_gamma #(
  parameter int SUM_FRACTION_BITS = apr_pkg::SUM_FRACTION_BITS_DEF,
  parameter int GAMMA_INDEX_BITS  = apr_pkg::GAMMA_INDEX_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [apr_pkg::SUM_W-1:0]   sum_red,
  input  logic [apr_pkg::SUM_W-1:0]   sum_green,
  input  logic [apr_pkg::SUM_W-1:0]   sum_blue,
  input  logic [apr_pkg::COUNT_W-1:0] sample_count,
  output logic                        done,
  output logic [apr_pkg::BYTE_W-1:0]  red_byte,
  output logic [apr_pkg::BYTE_W-1:0]  green_byte,
  output logic [apr_pkg::BYTE_W-1:0]  blue_byte
);

  localparam int F   = SUM_FRACTION_BITS;
  localparam int G   = GAMMA_INDEX_BITS;
  localparam int DW  = apr_pkg::COUNT_W + F;
  localparam int NCH = apr_pkg::CHANNELS;
  localparam int NB  = apr_pkg::BYTE_W;
  localparam int LAT = G + NB + 2;

  assign busy = 1'b0;

  apr_pkg::apr_ctl_t                 dctl [G+1];
  logic [DW-1:0]                     ddiv [G+1];
  logic [NCH-1:0][DW-1:0]            drem [G+1];
  logic [NCH-1:0][G-1:0]             dquo [G+1];

  apr_pkg::apr_ctl_t                 gctl  [NB+1];
  logic [NCH-1:0][G-1:0]             gidx  [NB+1];
  logic [NCH-1:0][NB-1:0]            gcode [NB+1];

  logic [NCH-1:0][apr_pkg::SUM_W-1:0] sums;
  logic [DW-1:0]                      full;
  logic [NCH-1:0]                     sat_next;
  logic [NCH-1:0][DW-1:0]             rem_next;

  assign sums = {sum_blue, sum_green, sum_red};
  assign full = DW'(sample_count) << F;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      rem_next[c] = DW'(sums[c]);
      sat_next[c] = (rem_next[c] >= full);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dctl[0].valid <= 1'b0;
    end else begin
      dctl[0].valid <= start;
    end
    dctl[0].blank <= (sample_count == '0);
    dctl[0].sat   <= sat_next;
    ddiv[0]       <= full;
    drem[0]       <= rem_next;
    dquo[0]       <= '0;
  end

  for (genvar i = 0; i < G; i++) begin : g_div
    apr_div_stage #(
      .DW (DW),
      .G  (G)
    ) u_div (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (dctl[i]),
      .div_in  (ddiv[i]),
      .rem_in  (drem[i]),
      .quo_in  (dquo[i]),
      .ctl_out (dctl[i+1]),
      .div_out (ddiv[i+1]),
      .rem_out (drem[i+1]),
      .quo_out (dquo[i+1])
    );
  end

  assign gctl[0]  = dctl[G];
  assign gidx[0]  = dquo[G];
  assign gcode[0] = '0;

  for (genvar j = 0; j < NB; j++) begin : g_gamma
    apr_gamma_stage #(
      .G   (G),
      .BIT (NB - 1 - j)
    ) u_gamma (
      .clk      (clk),
      .rst      (rst),
      .ctl_in   (gctl[j]),
      .idx_in   (gidx[j]),
      .code_in  (gcode[j]),
      .ctl_out  (gctl[j+1]),
      .idx_out  (gidx[j+1]),
      .code_out (gcode[j+1])
    );
  end

  logic [NCH-1:0][NB-1:0] byte_next;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      if (gctl[NB].blank) begin
        byte_next[c] = '0;
      end else if (gctl[NB].sat[c]) begin
        byte_next[c] = '1;
      end else begin
        byte_next[c] = gcode[NB][c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= gctl[NB].valid;
    end
    red_byte   <= byte_next[0];
    green_byte <= byte_next[1];
    blue_byte  <= byte_next[2];
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LAT done)
    else $error("transaction did not complete after the pipeline latency");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without a matching transaction");

  a_black: assert property (@(posedge clk) disable iff (rst)
    done && ($past(sample_count, LAT) == '0) |->
      (red_byte == '0) && (green_byte == '0) && (blue_byte == '0))
    else $error("zero sample count did not give black");

  a_red_sat: assert property (@(posedge clk) disable iff (rst)
    done && ($past(sample_count, LAT) != '0) &&
      (DW'($past(sum_red, LAT)) >= (DW'($past(sample_count, LAT)) << F)) |->
      (red_byte == '1))
    else $error("saturated red mean did not give full scale");

endmodule

FILE: dv/accumulated_pixel_resolve_gamma_tb.sv
module accumulated_pixel_resolve_gamma_tb;

  localparam int FRAC_BITS   = apr_pkg::SUM_FRACTION_BITS_DEF;
  localparam int IDX_BITS    = apr_pkg::GAMMA_INDEX_BITS_DEF;
  localparam int LUT_SIZE    = 1 << IDX_BITS;
  localparam int LATENCY     = IDX_BITS + 10;
  localparam int RAND_PIXELS = 1500;
  localparam int CYCLE_LIMIT = 200000;

  typedef logic [apr_pkg::SUM_W-1:0]   sum_t;
  typedef logic [apr_pkg::COUNT_W-1:0] count_t;
  typedef logic [apr_pkg::BYTE_W-1:0]  byte_t;
  typedef logic [255:0]                wide_t;

  typedef struct packed {
    byte_t red;
    byte_t green;
    byte_t blue;
  } rgb_t;

  class pixel_resolve_scoreboard;
    byte_t gamma_lut[LUT_SIZE];
    rgb_t  expected_pixels[$];
    int    errors;

    function new();
      wide_t       step_floor[256];
      wide_t       radix;
      wide_t       power;
      int unsigned level;
      errors = 0;
      radix = wide_t'(1);
      for (int k = 0; k < 11; k++) radix = radix * wide_t'(apr_pkg::GAMMA_SCALE);
      for (int b = 0; b < 256; b++) begin
        step_floor[b] = wide_t'(1);
        for (int k = 0; k < 11; k++) step_floor[b] = step_floor[b] * wide_t'(100 * b);
        step_floor[b] = step_floor[b] << (5 * IDX_BITS);
      end
      level = 0;
      for (int i = 0; i < LUT_SIZE; i++) begin
        power = radix;
        for (int k = 0; k < 5; k++) power = power * wide_t'(i);
        while (level < 255 && step_floor[level + 1] <= power) level++;
        gamma_lut[i] = byte_t'(level);
      end
    endfunction

    function byte_t resolve_byte(sum_t s, count_t n);
      logic [63:0] full;
      logic [63:0] idx;
      full = 64'(n) << FRAC_BITS;
      if (n == '0) return '0;
      if (64'(s) >= full) return 8'hFF;
      idx = (64'(s) << IDX_BITS) / full;
      return gamma_lut[idx[IDX_BITS-1:0]];
    endfunction

    function void note_pixel(sum_t r, sum_t g, sum_t b, count_t n);
      rgb_t px;
      px.red   = resolve_byte(r, n);
      px.green = resolve_byte(g, n);
      px.blue  = resolve_byte(b, n);
      expected_pixels.push_back(px);
    endfunction

    function void check_pixel(byte_t r, byte_t g, byte_t b);
      rgb_t px;
      if (expected_pixels.size() == 0) begin
        $error("unexpected result: red_byte %0d green_byte %0d blue_byte %0d", r, g, b);
        errors++;
        return;
      end
      px = expected_pixels.pop_front();
      if (r !== px.red) begin
        $error("red_byte: expected %0d, actual %0d", px.red, r);
        errors++;
      end
      if (g !== px.green) begin
        $error("green_byte: expected %0d, actual %0d", px.green, g);
        errors++;
      end
      if (b !== px.blue) begin
        $error("blue_byte: expected %0d, actual %0d", px.blue, b);
        errors++;
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst;
  logic   start;
  logic   busy;
  sum_t   sum_red;
  sum_t   sum_green;
  sum_t   sum_blue;
  count_t sample_count;
  logic   done;
  byte_t  red_byte;
  byte_t  green_byte;
  byte_t  blue_byte;

  pixel_resolve_scoreboard pixel_sb;
  int unsigned             cycle_count;

  accumulated_pixel_resolve_gamma #(
    .SUM_FRACTION_BITS(FRAC_BITS),
    .GAMMA_INDEX_BITS (IDX_BITS)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .sum_red     (sum_red),
    .sum_green   (sum_green),
    .sum_blue    (sum_blue),
    .sample_count(sample_count),
    .done        (done),
    .red_byte    (red_byte),
    .green_byte  (green_byte),
    .blue_byte   (blue_byte)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      pixel_sb.check_pixel(red_byte, green_byte, blue_byte);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // hold the transaction until taken, then record it
  task automatic drive_pixel(sum_t r, sum_t g, sum_t b, count_t n, int idle);
    if (idle > 0) begin
      start <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    start        <= 1'b1;
    sum_red      <= r;
    sum_green    <= g;
    sum_blue     <= b;
    sample_count <= n;
    do @(posedge clk); while (busy);
    pixel_sb.note_pixel(r, g, b, n);
  endtask

  function automatic count_t draw_count();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick < 8) return count_t'($urandom_range(1, 16));
    if (pick < 13) return count_t'($urandom_range(17, 65535));
    if (pick < 16) return count_t'($urandom);
    return count_t'(1) << $urandom_range(0, apr_pkg::COUNT_W - 1);
  endfunction

  function automatic sum_t draw_sum(count_t n);
    int unsigned pick;
    logic [63:0] full;
    full = 64'(n) << FRAC_BITS;
    pick = $urandom_range(0, 9);
    if (pick == 0 || full == 0 || full > 64'hFFFF_FFFF) return sum_t'($urandom);
    if (pick == 1) return sum_t'(full) + sum_t'($urandom_range(0, 3));
    if (pick == 2 && full > 4) return sum_t'(full) - sum_t'($urandom_range(1, 4));
    return sum_t'({$urandom, $urandom} % full);
  endfunction

  function automatic int draw_idle(bit steady);
    if (steady) return 0;
    return $urandom_range(0, 17);
  endfunction

  initial begin
    count_t n;
    bit     steady;
    pixel_sb = new();
    rst          <= 1'b1;
    start        <= 1'b0;
    sum_red      <= '0;
    sum_green    <= '0;
    sum_blue     <= '0;
    sample_count <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    drive_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'd0, 1);
    drive_pixel(32'h0, 32'h0, 32'h0, 24'd0, 0);
    drive_pixel(32'h0, 32'h1, 32'h10, 24'd1, 0);
    drive_pixel(32'h0001_0000, 32'h0000_FFFF, 32'h0001_0001, 24'd1, 3);
    drive_pixel(32'hFFFF_FFFF, 32'h0, 32'hFFFF_0000, 24'hFF_FFFF, 0);
    drive_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'd1, 0);
    drive_pixel(32'hFFFF_FFFF, 32'hFFFE_FFFF, 32'h7FFF_FFFF, 24'h00_FFFF, 2);
    drive_pixel(32'h0000_8000, 32'h0000_4000, 32'h0000_C000, 24'd1, 0);
    drive_pixel(32'h0000_0FFF, 32'h0000_1000, 32'h0000_0FF0, 24'd1, 0);
    drive_pixel(32'h0002_FFFF, 32'h0003_0000, 32'h0001_8000, 24'd3, 17);
    drive_pixel(32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000, 24'hAA_AAAA, 0);
    drive_pixel(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 24'h55_5555, 0);
    drive_pixel(32'h1234_5678, 32'h0FED_CBA9, 32'h0000_0000, 24'h80_0000, 1);
    drive_pixel(32'h0000_0010, 32'h0000_0020, 32'h0000_0030, 24'd1, 0);
    drive_pixel(32'h00FF_FFFF, 32'h0100_0000, 32'h0100_0001, 24'h00_0100, 0);

    steady = 1'b0;
    for (int i = 0; i < RAND_PIXELS; i++) begin
      if (i % 64 == 0) steady = ($urandom_range(0, 2) == 0);
      n = draw_count();
      drive_pixel(draw_sum(n), draw_sum(n), draw_sum(n), n, draw_idle(steady));
    end
    start <= 1'b0;

    while (pixel_sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (pixel_sb.errors == 0 && pixel_sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/apr_pkg.sv
hdl/apr_div_stage.sv
hdl/apr_gamma_stage.sv
hdl/accumulated_pixel_resolve_gamma.sv
dv/accumulated_pixel_resolve_gamma_tb.sv
